### rtl/clebu_pkg.sv
// ----------------------------------------------------------------------------
// clebu_pkg
// Shared types and constants of the cursor line edit buffer.
// ----------------------------------------------------------------------------
package clebu_pkg;

   localparam int CAPACITY = 256;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int LEN_W    = 9;
   localparam int CODE_W   = 32;
   localparam int CSR_W    = 2;

   // register indexes
   localparam logic [CSR_W-1:0] CSR_MAX_LENGTH = 2'd0;
   localparam logic [CSR_W-1:0] CSR_LEFT_KEY   = 2'd1;
   localparam logic [CSR_W-1:0] CSR_RIGHT_KEY  = 2'd2;

   localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = LEN_W'(CAPACITY);
   localparam logic [CODE_W-1:0] LEFT_KEY_RST   = 32'd1073741904;
   localparam logic [CODE_W-1:0] RIGHT_KEY_RST  = 32'd1073741903;

   localparam logic [CODE_W-1:0] KEY_BACKSPACE  = 32'd8;
   localparam logic [CODE_W-1:0] KEY_DELETE     = 32'd127;

   typedef struct packed {
      logic              is_char;
      logic [CODE_W-1:0] key_code;
      logic [7:0]        read_index;
   } req_type;

   typedef struct packed {
      logic              edit_applied;
      logic [8:0]        text_len;
      logic [8:0]        cursor_at;
      logic [CODE_W-1:0] read_data;
   } rsp_type;

   // edit command broadcast to every cell
   typedef struct packed {
      logic              ins;
      logic              del;
      logic [LEN_W-1:0]  pos;
      logic [CODE_W-1:0] code;
   } edit_ctrl_type;

endpackage

### rtl/clebu_cell.sv
// ----------------------------------------------------------------------------
// clebu_cell
// One codepoint slot of the buffer; shifts with its neighbours on an edit.
// ----------------------------------------------------------------------------
module clebu_cell (
   input  logic                           clock,
   input  clebu_pkg::edit_ctrl_type       ctrl,
   input  logic [clebu_pkg::LEN_W-1:0]    index,
   input  logic [clebu_pkg::CODE_W-1:0]   left_data,
   input  logic [clebu_pkg::CODE_W-1:0]   right_data,
   output logic [clebu_pkg::CODE_W-1:0]   data
);
   import clebu_pkg::*;

   logic [CODE_W-1:0] data_ff;
   logic [CODE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (index > ctrl.pos) begin
            data_in = left_data;
         end else if (index == ctrl.pos) begin
            data_in = ctrl.code;
         end
      end else if (ctrl.del) begin
         if (index >= ctrl.pos) begin
            data_in = right_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

### rtl/cursor_line_edit_buffer_unit.sv
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_unit
// Line edit buffer of codepoints with a cursor, driven by key press items.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one key press per item (is_char, key_code, read_index).
//    Unicode 8 is backspace, unicode 127 deletes at the cursor, any other
//    unicode code is inserted at the cursor while below the length limit.
//    Special keys matching the left / right codes move the cursor.
//  - rsp_ channel: one item per key press with the edit flag, length,
//    cursor and the codepoint at read_index (0 at or past the length).
//  - csr_ channel: register writes (max_length, left key, right key), always
//    ready; write only while the block is idle.
//  - Pipeline: the edit lands in the cell row at the accepting edge; the
//    read stage then selects one of the cells into the output register
//    once that register is free.
//  - A new key press is taken only after the last one has left that read stage.
//  - Reset: length and cursor go to 0, registers to their reset values.
//    Cell contents are left as they are; positions at or past the length
//    are never shown.
//  - Receiver stall: the result holds in the output register; one more
//    item may be taken and waits in the read stage until the slot frees.
// ----------------------------------------------------------------------------
module cursor_line_edit_buffer_unit (
   input  logic                       clock,
   input  logic                       reset,
   // key press items
   input  logic                       req_valid,
   output logic                       req_ready,
   input  clebu_pkg::req_type         req_payload,
   // result items
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output clebu_pkg::rsp_type         rsp_payload,
   // register writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [clebu_pkg::CSR_W-1:0]  csr_index,
   input  logic [clebu_pkg::CODE_W-1:0] csr_wdata
);
   import clebu_pkg::*;

   // configuration
   logic [LEN_W-1:0]  max_length_ff;
   logic [CODE_W-1:0] left_key_ff;
   logic [CODE_W-1:0] right_key_ff;

   // buffer state
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  cursor_ff, cursor_in;

   // read stage
   logic              busy_ff, busy_in;
   logic              pend_applied_ff, pend_applied_in;
   logic [IDX_W-1:0]  pend_idx_ff, pend_idx_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic              load_rsp;
   logic [LEN_W-1:0]  limit;
   edit_ctrl_type     ctrl;
   logic              applied;
   logic [CODE_W-1:0] cell_data [CAPACITY];

   assign accept    = req_valid && req_ready;
   assign req_ready = !busy_ff;
   assign csr_ready = 1'b1;
   assign limit     = (max_length_ff > LEN_W'(CAPACITY)) ? LEN_W'(CAPACITY) : max_length_ff;

   // decode the key press against the current length and cursor
   always_comb begin
      ctrl      = '0;
      ctrl.code = req_payload.key_code;
      applied   = 1'b0;
      len_in    = len_ff;
      cursor_in = cursor_ff;
      if (accept) begin
         if (req_payload.is_char) begin
            if (req_payload.key_code == KEY_BACKSPACE) begin
               if (cursor_ff != '0 && cursor_ff <= len_ff) begin
                  ctrl.del  = 1'b1;
                  ctrl.pos  = cursor_ff - LEN_W'(1);
                  len_in    = len_ff - LEN_W'(1);
                  cursor_in = cursor_ff - LEN_W'(1);
                  applied   = 1'b1;
               end
            end else if (req_payload.key_code == KEY_DELETE) begin
               if (cursor_ff < len_ff) begin
                  ctrl.del = 1'b1;
                  ctrl.pos = cursor_ff;
                  len_in   = len_ff - LEN_W'(1);
                  applied  = 1'b1;
               end
            end else if (len_ff < limit && cursor_ff <= len_ff) begin
               ctrl.ins  = 1'b1;
               ctrl.pos  = cursor_ff;
               len_in    = len_ff + LEN_W'(1);
               cursor_in = cursor_ff + LEN_W'(1);
               applied   = 1'b1;
            end
         end else if (req_payload.key_code == left_key_ff) begin
            // equal left and right codes resolve to a left move
            if (cursor_ff != '0) begin
               cursor_in = cursor_ff - LEN_W'(1);
            end
         end else if (req_payload.key_code == right_key_ff) begin
            if (cursor_ff < len_ff) begin
               cursor_in = cursor_ff + LEN_W'(1);
            end
         end
      end
   end

   // row of cells; each takes its left or right neighbour on a shift
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [CODE_W-1:0] left_w;
      logic [CODE_W-1:0] right_w;
      if (g == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_inner_l
         assign left_w = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_w = cell_data[g];
      end else begin : g_inner_r
         assign right_w = cell_data[g+1];
      end
      clebu_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .index      (LEN_W'(g)),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (cell_data[g])
      );
   end

   // read stage and output register
   assign load_rsp = busy_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      busy_in         = busy_ff;
      pend_applied_in = pend_applied_ff;
      pend_idx_in     = pend_idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_in          = rsp_ff;
      if (load_rsp) begin
         busy_in             = 1'b0;
         rsp_valid_in        = 1'b1;
         rsp_in.edit_applied = pend_applied_ff;
         rsp_in.text_len     = len_ff;
         rsp_in.cursor_at    = cursor_ff;
         rsp_in.read_data    = ({1'b0, pend_idx_ff} < len_ff) ? cell_data[pend_idx_ff] : '0;
      end
      if (accept) begin
         busy_in         = 1'b1;
         pend_applied_in = applied;
         pend_idx_in     = req_payload.read_index[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RST;
         left_key_ff   <= LEFT_KEY_RST;
         right_key_ff  <= RIGHT_KEY_RST;
         len_ff        <= '0;
         cursor_ff     <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_LENGTH: max_length_ff <= csr_wdata[LEN_W-1:0];
               CSR_LEFT_KEY:   left_key_ff   <= csr_wdata;
               CSR_RIGHT_KEY:  right_key_ff  <= csr_wdata;
               default: ;
            endcase
         end
         len_ff       <= len_in;
         cursor_ff    <= cursor_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_applied_ff <= pend_applied_in;
      pend_idx_ff     <= pend_idx_in;
      rsp_ff          <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // cursor never runs past the text
   a_cursor_in_text : assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= len_ff)
      else $error("cursor beyond text length");

   // length stays within the cell row
   a_len_in_capacity : assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(CAPACITY))
      else $error("length beyond capacity");

   // an accepted item occupies the read stage next cycle
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy_ff)
      else $error("accepted item not in read stage");

   // a pending read with a free slot reaches the output next cycle
   a_read_drains : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !rsp_valid_ff) |=> (rsp_valid_ff && !busy_ff))
      else $error("read stage did not drain");

   // buffer state only moves with an accepted item
   a_state_holds : assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(len_ff) && $stable(cursor_ff)))
      else $error("state changed without an item");

endmodule

### bench/cursor_line_edit_buffer_unit_tb.sv
// ----------------------------------------------------------------------------
// cursor_line_edit_buffer_unit_tb
// Drives key press items into the line edit buffer and checks every result
// item against a mirror of the text, length, cursor and registers. Directed
// edge cases come first, then random typing under several register settings
// with random stalls on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cursor_line_edit_buffer_unit_tb;

   import clebu_pkg::*;

   localparam int HOLD_CYCLES  = 100;   // long receiver hold-off
   localparam int DRAIN_CYCLES = 4;     // settling wait after the last result
   localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_ready;
   req_type             req_payload = '0;
   logic                rsp_valid;
   logic                rsp_ready   = 1'b0;
   rsp_type             rsp_payload;
   logic                csr_valid   = 1'b0;
   logic                csr_ready;
   logic [CSR_W-1:0]    csr_index   = '0;
   logic [CODE_W-1:0]   csr_wdata   = '0;

   // mirror of the buffer and its registers
   logic [CODE_W-1:0]   line_text [CAPACITY];
   logic [LEN_W-1:0]    line_len;
   logic [LEN_W-1:0]    line_cursor;
   logic [LEN_W-1:0]    cfg_limit;
   logic [CODE_W-1:0]   cfg_left_code;
   logic [CODE_W-1:0]   cfg_right_code;

   rsp_type             awaited_rsp [$];
   int unsigned         fail_count = 0;
   bit                  calm       = 1'b0;   // no idling on either side
   bit                  hold_req   = 1'b0;   // asks the receiver to hold off
   int                  hold_left  = 0;
   int                  quiet_cycles;

   cursor_line_edit_buffer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Mirror: applies one key press and returns the result it should give
   // -------------------------------------------------------------------------
   function automatic rsp_type edit_line(input req_type key);
      rsp_type res;
      int      lim;
      int      i;
      res = '0;
      // limit never exceeds the cell count
      lim = (cfg_limit < CAPACITY) ? int'(cfg_limit) : CAPACITY;
      if (key.is_char) begin
         if (key.key_code == KEY_BACKSPACE) begin
            if (line_cursor > 0) begin
               for (i = line_cursor - 1; i + 1 < line_len; i++)
                  line_text[i] = line_text[i + 1];
               line_len--;
               line_cursor--;
               res.edit_applied = 1'b1;
            end
         end else if (key.key_code == KEY_DELETE) begin
            if (line_cursor < line_len) begin
               for (i = line_cursor; i + 1 < line_len; i++)
                  line_text[i] = line_text[i + 1];
               line_len--;
               res.edit_applied = 1'b1;
            end
         end else if (line_len < lim) begin
            for (i = line_len; i > line_cursor; i--)
               line_text[i] = line_text[i - 1];
            line_text[line_cursor] = key.key_code;
            line_len++;
            line_cursor++;
            res.edit_applied = 1'b1;
         end
      end else if (key.key_code == cfg_left_code) begin
         // left wins when both codes are equal
         if (line_cursor > 0)
            line_cursor--;
      end else if (key.key_code == cfg_right_code) begin
         if (line_cursor < line_len)
            line_cursor++;
      end
      res.text_len  = line_len;
      res.cursor_at = line_cursor;
      res.read_data = (key.read_index < line_len) ? line_text[key.read_index] : '0;
      return res;
   endfunction

   // read positions biased towards the live part of the text, its end and the cursor
   function automatic logic [7:0] pick_read_index();
      logic [7:0] idx;
      case ($urandom_range(0, 3))
         0: idx = 8'($urandom_range(0, 255));
         1: idx = (line_len == 0) ? 8'd0 : 8'($urandom_range(0, line_len - 1));
         2: idx = (line_len > 255) ? 8'd255 : line_len[7:0];
         default: idx = (line_cursor > 255) ? 8'd255 : line_cursor[7:0];
      endcase
      return idx;
   endfunction

   // -------------------------------------------------------------------------
   // Sender: offers one key press, waits for it to be taken, predicts it.
   // Valid is only lowered for an idle gap or by drain_block, so it never
   // gets two assignments in one step.
   // -------------------------------------------------------------------------
   task automatic press_key(input logic uni, input logic [CODE_W-1:0] code,
                            input logic [7:0] idx);
      req_type key;
      key.is_char    = uni;
      key.key_code   = code;
      key.read_index = idx;
      if (!calm && $urandom_range(0, 99) < 33) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
         req_valid <= 1'b1;
      end else if (!req_valid) begin
         req_valid <= 1'b1;
      end
      req_payload <= key;
      do @(posedge clock); while (!req_ready);
      awaited_rsp.push_back(edit_line(key));
   endtask

   // stop offering, let every result come out, then wait out the pipeline
   task automatic drain_block();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_W-1:0] index, input logic [CODE_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_MAX_LENGTH: cfg_limit      = value[LEN_W-1:0];
         CSR_LEFT_KEY:   cfg_left_code  = value;
         CSR_RIGHT_KEY:  cfg_right_code = value;
         default: ;
      endcase
   endtask

   // weighted random typing
   task automatic type_random_keys(input int count, input int w_ins, input int w_bs,
                                   input int w_del, input int w_move, input int w_noise);
      int          total;
      int          pick;
      logic        uni;
      logic [31:0] code;
      total = w_ins + w_bs + w_del + w_move + w_noise;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, total - 1);
         if (pick < w_ins) begin
            uni  = 1'b1;
            code = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(32, 126));
         end else if (pick < w_ins + w_bs) begin
            uni  = 1'b1;
            code = KEY_BACKSPACE;
         end else if (pick < w_ins + w_bs + w_del) begin
            uni  = 1'b1;
            code = KEY_DELETE;
         end else if (pick < w_ins + w_bs + w_del + w_move) begin
            uni  = 1'b0;
            code = $urandom_range(0, 1) ? cfg_left_code : cfg_right_code;
         end else begin
            // noise: unknown special keys, edit codes sent as special keys,
            // and a special key code sent as a character
            case ($urandom_range(0, 2))
               0: begin uni = 1'b0; code = $urandom; end
               1: begin uni = 1'b0; code = $urandom_range(0, 1) ? KEY_DELETE : KEY_BACKSPACE; end
               default: begin uni = 1'b1; code = cfg_right_code; end
            endcase
         end
         press_key(uni, code, pick_read_index());
      end
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------
   task automatic test_directed_keys();
      press_key(1'b0, cfg_right_code, 8'd0);      // move right in an empty line
      press_key(1'b0, cfg_left_code, 8'd255);     // move left at the start
      press_key(1'b1, KEY_BACKSPACE, 8'd0);       // backspace at the start
      press_key(1'b1, KEY_DELETE, 8'd0);          // delete at the end
      press_key(1'b1, 32'hFFFF_FFFF, 8'd0);
      press_key(1'b1, 32'h0000_0000, 8'd0);
      press_key(1'b0, cfg_left_code, 8'd1);
      press_key(1'b1, 32'h8000_0001, 8'd1);       // insert mid-line
      press_key(1'b1, KEY_DELETE, 8'd2);          // delete at the cursor
      press_key(1'b1, KEY_DELETE, 8'd1);          // cursor now at the end
      press_key(1'b0, cfg_right_code, 8'd1);      // move past the end
      press_key(1'b0, KEY_BACKSPACE, 8'd0);       // special key matching nothing
      press_key(1'b1, cfg_left_code, 8'd2);       // special code as a character
      repeat (3) press_key(1'b0, cfg_left_code, 8'd0);
      press_key(1'b1, KEY_BACKSPACE, 8'd255);
      press_key(1'b1, KEY_DELETE, 8'd0);          // delete at the start
   endtask

   task automatic test_length_limits();
      drain_block();
      write_reg(CSR_MAX_LENGTH, 32'd3);
      press_key(1'b1, 32'h0000_0041, 8'd0);       // fills to the limit
      press_key(1'b1, 32'h0000_0042, 8'd1);       // full: refused
      drain_block();
      write_reg(CSR_MAX_LENGTH, 32'd1);           // limit below the length
      press_key(1'b1, 32'h0000_0043, 8'd2);
      press_key(1'b1, KEY_DELETE, 8'd0);
      press_key(1'b0, cfg_right_code, 8'd1);
   endtask

   task automatic test_equal_move_codes();
      drain_block();
      write_reg(CSR_RIGHT_KEY, cfg_left_code);
      press_key(1'b0, cfg_right_code, 8'd0);
      press_key(1'b0, cfg_right_code, 8'd0);
   endtask

   task automatic test_mixed_typing();
      drain_block();
      write_reg(CSR_MAX_LENGTH, 32'(MAX_LENGTH_RST));
      write_reg(CSR_LEFT_KEY, LEFT_KEY_RST);
      write_reg(CSR_RIGHT_KEY, RIGHT_KEY_RST);
      calm = 1'b1;                                // back to back on both sides
      type_random_keys(120, 45, 15, 10, 24, 6);
      calm = 1'b0;
      type_random_keys(130, 45, 15, 10, 24, 6);
   endtask

   task automatic test_zero_limit();
      drain_block();
      write_reg(CSR_MAX_LENGTH, 32'd0);
      write_reg(CSR_LEFT_KEY, 32'h0000_0000);
      write_reg(CSR_RIGHT_KEY, 32'hFFFF_FFFF);
      type_random_keys(60, 40, 15, 15, 25, 5);
   endtask

   task automatic test_small_limit();
      drain_block();
      write_reg(CSR_MAX_LENGTH, 32'd5);
      write_reg(CSR_LEFT_KEY, $urandom);
      write_reg(CSR_RIGHT_KEY, $urandom);
      type_random_keys(200, 40, 15, 15, 25, 5);
   endtask

   // receiver holds off while the sender keeps offering, then the sender
   // waits for every result before going on
   task automatic test_backpressure();
      calm     = 1'b1;
      hold_req = 1'b1;
      type_random_keys(40, 45, 15, 10, 24, 6);
      calm     = 1'b0;
      drain_block();
   endtask

   task automatic test_fill_capacity();
      write_reg(CSR_MAX_LENGTH, 32'h0000_01FF);   // limit above the cell count
      type_random_keys(330, 90, 3, 2, 4, 1);
   endtask

   task automatic test_shrink_over_limit();
      drain_block();
      write_reg(CSR_MAX_LENGTH, 32'd20);
      type_random_keys(200, 15, 40, 30, 12, 3);
   endtask

   task automatic test_equal_codes_random();
      logic [CODE_W-1:0] code;
      drain_block();
      code = $urandom;
      write_reg(CSR_MAX_LENGTH, 32'd300);
      write_reg(CSR_LEFT_KEY, code);
      write_reg(CSR_RIGHT_KEY, code);
      type_random_keys(100, 40, 15, 10, 30, 5);
   endtask

   // -------------------------------------------------------------------------
   // Receiver: random stalls, or a long hold-off when asked
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(0, 99) >= 33);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   // every result item is compared with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_rsp.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result, expected none, actual 0x%0h", $time,
                     rsp_payload);
         end else begin
            want = awaited_rsp.pop_front();
            check_field("edit_applied", 32'(want.edit_applied), 32'(rsp_payload.edit_applied));
            check_field("text_len", 32'(want.text_len), 32'(rsp_payload.text_len));
            check_field("cursor_at", 32'(want.cursor_at), 32'(rsp_payload.cursor_at));
            check_field("read_data", want.read_data, rsp_payload.read_data);
         end
      end
   end

   // watchdog on cycles with no handshake on any channel
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               STALL_LIMIT, awaited_rsp.size());
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      line_len       = '0;
      line_cursor    = '0;
      cfg_limit      = MAX_LENGTH_RST;
      cfg_left_code  = LEFT_KEY_RST;
      cfg_right_code = RIGHT_KEY_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_keys();
      test_length_limits();
      test_equal_move_codes();
      test_mixed_typing();
      test_zero_limit();
      test_small_limit();
      test_backpressure();
      test_fill_capacity();
      test_shrink_over_limit();
      test_equal_codes_random();
      drain_block();

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
